// ===== design/dutc_pkg.sv =====
// dutc_pkg: shared types, constants and calendar tables for dos_unix_time_convert.
// Depends on nothing; the top level uses it through scoped names.
package dutc_pkg;

  localparam int NUM_STAGES = 10;

  localparam int IN_DATA_W  = 72;  // dos_word + unix_seconds, padded to bytes
  localparam int OUT_DATA_W = 72;  // result_unix + result_dos, padded to bytes

  // direction select carried on in_tuser
  typedef enum logic {
    CMD_DOS2UNIX = 1'b0,
    CMD_UNIX2DOS = 1'b1
  } cmd_t;

  // Unix seconds of 1980-01-01 00:00:00 and 2107-12-31 23:59:59
  localparam logic [32:0] DOS_MIN_UNIX = 33'd315532800;
  localparam logic [32:0] DOS_MAX_UNIX = 33'd4354819199;

  localparam logic [16:0] DAY_SECS  = 17'd86400;
  localparam logic [16:0] HOUR_SECS = 17'd3600;
  localparam logic [5:0]  MIN_SECS  = 6'd60;
  localparam logic [10:0] QUAD_DAYS = 11'd1461;   // days in a four-year cycle

  // reciprocals: floor(2^k / divisor)
  localparam logic [15:0] RECIP_675  = 16'd49710;  // k = 25
  localparam logic [15:0] RECIP_1461 = 16'd45933;  // k = 26
  localparam logic [10:0] RECIP_3600 = 11'd1165;   // k = 22
  localparam logic [10:0] RECIP_60   = 11'd1092;   // k = 16

  // day index of 2100-03-01 counted from 1980-01-01; 2100 is no leap year
  localparam logic [15:0] SKIP_2100 = 16'd43889;

  // days in ten common years from 1970-01-01; the leap days come from the year term
  localparam logic [16:0] DAYS_1970_1980 = 17'd3650;
  localparam logic [6:0]  YEAR_2100_OFS  = 7'd120;

  // first day of a month within a common year, month index 0..11
  function automatic logic [8:0] month_start(input logic [3:0] idx);
    logic [8:0] v;
    case (idx)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd59;
      4'd3:    v = 9'd90;
      4'd4:    v = 9'd120;
      4'd5:    v = 9'd151;
      4'd6:    v = 9'd181;
      4'd7:    v = 9'd212;
      4'd8:    v = 9'd243;
      4'd9:    v = 9'd273;
      4'd10:   v = 9'd304;
      4'd11:   v = 9'd334;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  // first day of a month, with the leap day counted from March on
  function automatic logic [8:0] month_begin(input logic [3:0] idx, input logic leap);
    return month_start(idx) + {8'd0, leap && (idx >= 4'd2)};
  endfunction

  // one pipeline stage; each stage fills the fields it produces
  typedef struct packed {
    logic        cmd;
    logic        zero;
    logic        err;
    // DOS to Unix path
    logic [15:0] days;
    logic [4:0]  hour;
    logic [5:0]  mins;
    logic [4:0]  sec2;
    logic [32:0] dsec;
    logic [16:0] hms;
    logic [32:0] res_unix;
    // Unix to DOS path
    logic [31:0] t;
    logic [40:0] p1;
    logic [15:0] q0;
    logic [31:0] prod;
    logic [15:0] dd;
    logic [16:0] rem;
    logic [30:0] pd;
    logic [26:0] ph;
    logic [4:0]  qq0;
    logic [4:0]  h0;
    logic [15:0] pq;
    logic [16:0] ph3600;
    logic [4:0]  quad;
    logic [10:0] dq;
    logic [4:0]  hour_u;
    logic [11:0] rr;
    logic [1:0]  yq;
    logic [8:0]  doy;
    logic        leap;
    logic [21:0] pm;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [5:0]  min0;
    logic [11:0] pmin;
    logic [31:0] res_dos;
  } stage_t;

endpackage

// ===== design/dos_unix_time_convert.sv =====
// dos_unix_time_convert: DOS date/time word <-> Unix seconds, ten-stage pipeline.
// Depends on dutc_pkg (types, constants, month tables).
//
// Usage
//   Input stream: in_tdata[31:0] dos_word, in_tdata[64:32] unix_seconds,
//   in_tuser selects the direction (0 DOS to Unix, 1 Unix to DOS).
//   Output stream: out_tdata[32:0] result_unix, out_tdata[64:33] result_dos,
//   out_tuser flags a bad month or a time outside 1980..2107; the result is
//   then zero. A zero input gives a zero result with no flag.
// Order and throughput
//   Every transfer comes out in the order it was accepted, one result per
//   transfer. One transfer is taken per cycle while in_tready is high; the
//   work is split over ten register stages: multipliers (days to
//   seconds, reciprocal divides by 86400, 1461, 3600 and 60) and
//   compare-and-subtract fixups.
// Reset and stalls
//   rst_n (synchronous, active low) empties the pipeline; stalls lose no result
//   and invent none. Each stage has its own valid bit and moves forward when the
//   next stage is empty or moving, so bubbles close up while out_tready is
//   low and in_tready drops only once all ten stages hold transfers.
module dos_unix_time_convert (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [dutc_pkg::IN_DATA_W-1:0]   in_tdata,   // dos_word, unix_seconds, zero pad
  input  logic                             in_tuser,   // command
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [dutc_pkg::OUT_DATA_W-1:0]  out_tdata,  // result_unix, result_dos, zero pad
  output logic                             out_tuser   // range_error
);

  localparam int N = dutc_pkg::NUM_STAGES;

  dutc_pkg::stage_t stg_r   [N];
  dutc_pkg::stage_t stg_nxt [N];
  logic [N-1:0]     v_r;
  logic [N-1:0]     v_nxt;
  logic [N:0]       rdy;
  logic [N-1:0]     up_valid;
  logic [N-1:0]     ld;

  // ---------------- handshake: per-stage ready chain ----------------
  always_comb begin
    rdy[N] = out_tready;
    for (int k = N - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    up_valid = {v_r[N-2:0], in_tvalid};
    for (int k = 0; k < N; k++) begin
      ld[k]    = rdy[k] && up_valid[k];
      v_nxt[k] = rdy[k] ? up_valid[k] : v_r[k];
    end
  end

  assign in_tready = rdy[0];

  // ---------------- stage 1: unpack, day count, range check ----------------
  always_comb begin : s1_comb
    logic [31:0] w;
    logic [32:0] s;
    logic [6:0]  y7;
    logic [3:0]  mon;
    logic [4:0]  dy;
    logic        bad;
    logic        lp;
    logic        oor;
    logic        u2d;
    logic [16:0] days_w;
    w   = in_tdata[31:0];
    s   = in_tdata[64:32];
    y7  = w[31:25];
    mon = w[24:21];
    dy  = w[20:16];
    u2d = (in_tuser == dutc_pkg::CMD_UNIX2DOS);
    bad = (mon == 4'd0) || (mon > 4'd12);
    lp  = (y7[1:0] == 2'd0) && (y7 != dutc_pkg::YEAR_2100_OFS);
    oor = (s < dutc_pkg::DOS_MIN_UNIX) || (s > dutc_pkg::DOS_MAX_UNIX);
    // century terms of the leap count only bite in 2100 and later
    days_w = dutc_pkg::DAYS_1970_1980
           + 17'(17'(y7) * 17'd365)
           + 17'(dutc_pkg::month_start(mon - 4'd1))
           + 17'((8'(y7) + 8'd12) >> 2)
           - {16'd0, y7 >= dutc_pkg::YEAR_2100_OFS}
           - {16'd0, lp && (mon <= 4'd2)}
           + 17'(dy)
           - 17'd1;
    stg_nxt[0]      = '0;
    stg_nxt[0].cmd  = in_tuser;
    stg_nxt[0].zero = u2d ? (s == 33'd0) : (w == 32'd0);
    stg_nxt[0].err  = u2d ? ((s != 33'd0) && oor) : ((w != 32'd0) && bad);
    stg_nxt[0].days = days_w[15:0];
    stg_nxt[0].hour = w[15:11];
    stg_nxt[0].mins = w[10:5];
    stg_nxt[0].sec2 = w[4:0];
    stg_nxt[0].t    = 32'(s - dutc_pkg::DOS_MIN_UNIX);
  end

  // ---------------- stage 2: days to seconds; t / 86400 estimate ----------------
  always_comb begin
    stg_nxt[1]      = stg_r[0];
    stg_nxt[1].dsec = 33'(stg_r[0].days) * 33'(dutc_pkg::DAY_SECS);
    stg_nxt[1].hms  = 17'(stg_r[0].hour) * dutc_pkg::HOUR_SECS
                    + 17'(stg_r[0].mins) * 17'(dutc_pkg::MIN_SECS)
                    + {11'd0, stg_r[0].sec2, 1'b0};
    // 86400 = 128 * 675
    stg_nxt[1].p1   = 41'(stg_r[0].t[31:7]) * 41'(dutc_pkg::RECIP_675);
  end

  // ---------------- stage 3: Unix result; quotient back-multiply ----------------
  always_comb begin
    stg_nxt[2]          = stg_r[1];
    stg_nxt[2].res_unix = ((stg_r[1].cmd == dutc_pkg::CMD_UNIX2DOS) || stg_r[1].zero ||
                           stg_r[1].err) ? 33'd0 : stg_r[1].dsec + 33'(stg_r[1].hms);
    stg_nxt[2].q0       = stg_r[1].p1[40:25];
    stg_nxt[2].prod     = 32'(32'(stg_r[1].p1[40:25]) * 32'(dutc_pkg::DAY_SECS));
  end

  // ---------------- stage 4: day / second-of-day fixup ----------------
  always_comb begin : s4_comb
    logic [17:0] r;
    logic [15:0] q;
    r = 18'(33'(stg_r[2].t) - 33'(stg_r[2].prod));
    q = stg_r[2].q0;
    if (r >= 18'(dutc_pkg::DAY_SECS)) begin
      q = q + 16'd1;
      r = r - 18'(dutc_pkg::DAY_SECS);
    end
    stg_nxt[3]     = stg_r[2];
    stg_nxt[3].rem = r[16:0];
    // insert a phantom Feb 29 in 2100 so four-year cycles stay uniform
    stg_nxt[3].dd  = q + {15'd0, q >= dutc_pkg::SKIP_2100};
  end

  // ---------------- stage 5: reciprocal products for /1461 and /3600 ----------------
  always_comb begin
    stg_nxt[4]    = stg_r[3];
    stg_nxt[4].pd = 31'(32'(stg_r[3].dd) * 32'(dutc_pkg::RECIP_1461));
    stg_nxt[4].ph = 27'(28'(stg_r[3].rem) * 28'(dutc_pkg::RECIP_3600));
  end

  // ---------------- stage 6: back-multiply estimates ----------------
  always_comb begin
    stg_nxt[5]        = stg_r[4];
    stg_nxt[5].qq0    = stg_r[4].pd[30:26];
    stg_nxt[5].h0     = stg_r[4].ph[26:22];
    stg_nxt[5].pq     = 16'(16'(stg_r[4].pd[30:26]) * 16'(dutc_pkg::QUAD_DAYS));
    stg_nxt[5].ph3600 = 17'(stg_r[4].ph[26:22]) * dutc_pkg::HOUR_SECS;
  end

  // ---------------- stage 7: quad-year and hour fixup ----------------
  always_comb begin : s7_comb
    logic [16:0] dq0;
    logic [17:0] rr0;
    logic [4:0]  qd;
    logic [4:0]  hr;
    dq0 = 17'(stg_r[5].dd) - 17'(stg_r[5].pq);
    qd  = stg_r[5].qq0;
    if (dq0 >= 17'(dutc_pkg::QUAD_DAYS)) begin
      dq0 = dq0 - 17'(dutc_pkg::QUAD_DAYS);
      qd  = qd + 5'd1;
    end
    rr0 = 18'(stg_r[5].rem) - 18'(stg_r[5].ph3600);
    hr  = stg_r[5].h0;
    if (rr0 >= 18'(dutc_pkg::HOUR_SECS)) begin
      rr0 = rr0 - 18'(dutc_pkg::HOUR_SECS);
      hr  = hr + 5'd1;
    end
    stg_nxt[6]        = stg_r[5];
    stg_nxt[6].quad   = qd;
    stg_nxt[6].dq     = dq0[10:0];
    stg_nxt[6].hour_u = hr;
    stg_nxt[6].rr     = rr0[11:0];
  end

  // ---------------- stage 8: year within the cycle; minute estimate ----------------
  always_comb begin
    stg_nxt[7] = stg_r[6];
    if (stg_r[6].dq < 11'd366) begin
      stg_nxt[7].yq   = 2'd0;
      stg_nxt[7].doy  = stg_r[6].dq[8:0];
      stg_nxt[7].leap = 1'b1;
    end else if (stg_r[6].dq < 11'd731) begin
      stg_nxt[7].yq   = 2'd1;
      stg_nxt[7].doy  = 9'(stg_r[6].dq - 11'd366);
      stg_nxt[7].leap = 1'b0;
    end else if (stg_r[6].dq < 11'd1096) begin
      stg_nxt[7].yq   = 2'd2;
      stg_nxt[7].doy  = 9'(stg_r[6].dq - 11'd731);
      stg_nxt[7].leap = 1'b0;
    end else begin
      stg_nxt[7].yq   = 2'd3;
      stg_nxt[7].doy  = 9'(stg_r[6].dq - 11'd1096);
      stg_nxt[7].leap = 1'b0;
    end
    stg_nxt[7].pm = 22'(23'(stg_r[6].rr) * 23'(dutc_pkg::RECIP_60));
  end

  // ---------------- stage 9: month and day; minute back-multiply ----------------
  always_comb begin : s9_comb
    logic [11:0] ge;
    logic [3:0]  cnt;
    logic [8:0]  first;
    ge[0] = 1'b1;
    for (int m = 1; m < 12; m++) begin
      ge[m] = stg_r[7].doy >= dutc_pkg::month_begin(4'(m), stg_r[7].leap);
    end
    cnt   = 4'($countones(ge[11:1]));
    first = dutc_pkg::month_begin(cnt, stg_r[7].leap);
    stg_nxt[8]       = stg_r[7];
    stg_nxt[8].month = cnt + 4'd1;
    stg_nxt[8].day   = 5'(stg_r[7].doy - first + 9'd1);
    stg_nxt[8].min0  = stg_r[7].pm[21:16];
    stg_nxt[8].pmin  = 12'(stg_r[7].pm[21:16]) * 12'(dutc_pkg::MIN_SECS);
  end

  // ---------------- stage 10: minute fixup, pack DOS word ----------------
  always_comb begin : s10_comb
    logic [11:0] sc;
    logic [5:0]  mn;
    sc = stg_r[8].rr - stg_r[8].pmin;
    mn = stg_r[8].min0;
    if (sc >= 12'(dutc_pkg::MIN_SECS)) begin
      sc = sc - 12'(dutc_pkg::MIN_SECS);
      mn = mn + 6'd1;
    end
    stg_nxt[9] = stg_r[8];
    if ((stg_r[8].cmd != dutc_pkg::CMD_UNIX2DOS) || stg_r[8].zero || stg_r[8].err) begin
      stg_nxt[9].res_dos = 32'd0;
    end else begin
      stg_nxt[9].res_dos = {stg_r[8].quad, stg_r[8].yq, stg_r[8].month, stg_r[8].day,
                            stg_r[8].hour_u, mn, sc[5:1]};
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < N; k++) begin
      if (ld[k]) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  assign out_tvalid = v_r[N-1];
  assign out_tdata  = {7'd0, stg_r[N-1].res_dos, stg_r[N-1].res_unix};
  assign out_tuser  = stg_r[N-1].err;

  // ---------------- assertions ----------------
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("flagged result is not zero");

  a_dir_unix: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (stg_r[N-1].cmd == dutc_pkg::CMD_UNIX2DOS) |->
      stg_r[N-1].res_unix == 33'd0)
    else $error("Unix result on a DOS-direction transfer");

  a_dir_dos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (stg_r[N-1].cmd == dutc_pkg::CMD_DOS2UNIX) |->
      stg_r[N-1].res_dos == 32'd0)
    else $error("DOS result on a Unix-direction transfer");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (&v_r) && !out_tready)
    else $error("input stalled while pipeline has room");

  a_cal_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (stg_r[N-1].cmd == dutc_pkg::CMD_UNIX2DOS) &&
      stg_r[N-1].res_dos != 32'd0 |->
      stg_r[N-1].res_dos[24:21] >= 4'd1 && stg_r[N-1].res_dos[24:21] <= 4'd12 &&
      stg_r[N-1].res_dos[20:16] != 5'd0 && stg_r[N-1].res_dos[15:11] <= 5'd23)
    else $error("calendar breakdown out of range");

endmodule
